// File: src/rh_from_dew_point_macros.svh
// assertion macros for the relative humidity block checkers
`ifndef RH_FROM_DEW_POINT_MACROS_SVH
`define RH_FROM_DEW_POINT_MACROS_SVH

// concurrent check, muted while reset is active
`define RHDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// concurrent check that also holds while reset is active
`define RHDP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: src/rhdp_pkg.sv
// shared constants and types of the relative humidity pipeline
package rhdp_pkg;

  // temperature lane
  localparam int TEMP_W      = 16;
  localparam int QUO_W       = 23;
  localparam int NUM_W       = 37;
  localparam int DV_W        = 17;
  localparam int F_W         = 24;
  localparam int DIV_PER_STG = 4;
  localparam int DIV_STG     = (QUO_W + DIV_PER_STG - 1) / DIV_PER_STG;
  localparam int MT_LAT      = DIV_STG + 4;

  localparam logic signed [16:0] FREEZE_OFS = 17'sd3200;
  localparam logic signed [15:0] TEMP_FLOOR = -16'sd20000;
  localparam logic [15:0]        MAGNUS_B   = 16'd24304;
  // 2 * 17.625 * 65536, the doubled numerator scale of the magnus term
  localparam logic [21:0]        MAGNUS_2A  = 22'd2310144;
  // floor(2^21 / 9)
  localparam logic [17:0]        RECIP9     = 18'd233016;
  localparam int                 RECIP9_SH  = 21;

  // exponent datapath
  localparam int D_W     = 25;
  localparam int AD_W    = 20;
  localparam int MAG_W   = 29;
  localparam int SUM_W   = 32;
  localparam int PROD_W  = MAG_W + AD_W;
  localparam int RCP_W   = 31;
  localparam int PM_W    = MAG_W + RCP_W;
  localparam int RCP_SH  = 30;
  localparam int TAY_SH  = 20;
  localparam int N_TERMS = 12;
  localparam int E_W     = 31;
  localparam int SQ_W    = 2 * E_W;
  localparam int N_SQR   = 4;
  localparam int Q       = 28;
  localparam int RF_W    = 45;
  localparam int RH_W    = 16;

  localparam logic signed [D_W-1:0] D_MIN    = -25'sd655360;
  localparam logic signed [D_W-1:0] D_MAX    = 25'sd131072;
  localparam logic [MAG_W-1:0]      Q28_ONE  = 29'd268435456;
  localparam logic [63:0]           Q28_HALF = 64'd134217728;
  localparam logic [13:0]           RH_SCALE = 14'd10000;

  // term divisor k split into odd part and power of two
  localparam int unsigned K_ODD [1:N_TERMS] = '{1, 1, 3, 1, 5, 3, 7, 1, 9, 5, 11, 3};
  localparam int unsigned K_SH  [1:N_TERMS] = '{0, 1, 0, 2, 0, 1, 0, 3, 0, 1, 0, 2};

  typedef struct packed {
    logic                    lo;
    logic                    hi;
    logic                    dneg;
    logic [AD_W-1:0]         ad;
    logic [MAG_W-1:0]        mag;
    logic signed [SUM_W-1:0] sum;
    logic [PROD_W-1:0]       p;
    logic [MAG_W-1:0]        n;
    logic [PM_W-1:0]         pm;
  } tay_t;

  typedef struct packed {
    logic            lo;
    logic            hi;
    logic [E_W-1:0]  e;
    logic [SQ_W-1:0] sq;
  } sqr_t;

endpackage

// File: src/rhdp_mterm.sv
// one temperature lane: unit conversion, clamp and pipelined magnus divide
module rhdp_mterm import rhdp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     fahr_i,
  input  logic signed [TEMP_W-1:0] th_i,
  output logic signed [F_W-1:0]    f_o
);

  // stage 1: (t - 32) * 5 magnitude and reciprocal multiply by 1/9
  logic signed [TEMP_W-1:0] th_q;
  logic                     fahr_q, fneg_q;
  logic [17:0]              n9_q;
  logic [35:0]              prod9_q;
  logic signed [16:0]       dif;
  logic signed [18:0]       p5;
  logic [17:0]              pmag, n9;

  always_comb begin
    dif  = 17'(th_i) - FREEZE_OFS;
    p5   = 19'(dif) * 19'sd5;
    pmag = p5[18] ? 18'(-p5) : 18'(p5);
    n9   = pmag + 18'd4;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      th_q    <= th_i;
      fahr_q  <= fahr_i;
      fneg_q  <= p5[18];
      n9_q    <= n9;
      prod9_q <= 36'(n9) * 36'(RECIP9);
    end
  end

  // stage 2: quotient correction, sign and cold clamp
  logic signed [TEMP_W-1:0] tc_q;
  logic [14:0]              q0, q9;
  logic [17:0]              r9;
  logic signed [TEMP_W-1:0] qs, tv;

  always_comb begin
    q0 = prod9_q[RECIP9_SH +: 15];
    r9 = n9_q - 18'(18'(q0) * 18'd9);
    q9 = q0 + 15'(r9 >= 18'd9);
    qs = {1'b0, q9};
    tv = fahr_q ? (fneg_q ? -qs : qs) : th_q;
    if (tv < TEMP_FLOOR) begin
      tv = TEMP_FLOOR;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tc_q <= tv;
    end
  end

  // stage 3: rounded numerator and doubled denominator
  logic [DV_W:0]   rem_q [0:DIV_STG];
  logic [QUO_W-1:0] nsh_q [0:DIV_STG];
  logic [QUO_W-1:0] quo_q [0:DIV_STG];
  logic [DV_W-1:0]  dv_q  [0:DIV_STG];
  logic             neg_q [0:DIV_STG];
  logic [14:0]      tmag;
  logic [15:0]      dsum;
  logic [NUM_W-1:0] num;

  always_comb begin
    tmag = tc_q[15] ? 15'(-tc_q) : tc_q[14:0];
    dsum = MAGNUS_B + 16'(tc_q);
    num  = 37'(tmag) * 37'(MAGNUS_2A) + 37'(dsum);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {{(DV_W + 1 - (NUM_W - QUO_W)){1'b0}}, num[NUM_W-1:QUO_W]};
      nsh_q[0] <= num[QUO_W-1:0];
      quo_q[0] <= '0;
      dv_q[0]  <= {dsum, 1'b0};
      neg_q[0] <= tc_q[15];
    end
  end

  // restoring divide, a few quotient bits per stage
  for (genvar s = 0; s < DIV_STG; s++) begin : g_div
    logic [DV_W:0]    r, t;
    logic [QUO_W-1:0] ns, qu;

    always_comb begin
      r  = rem_q[s];
      ns = nsh_q[s];
      qu = quo_q[s];
      t  = '0;
      for (int j = 0; j < DIV_PER_STG; j++) begin
        if (s * DIV_PER_STG + j < QUO_W) begin
          t  = {r[DV_W-1:0], ns[QUO_W-1]};
          ns = {ns[QUO_W-2:0], 1'b0};
          if (t >= {1'b0, dv_q[s]}) begin
            r  = t - {1'b0, dv_q[s]};
            qu = {qu[QUO_W-2:0], 1'b1};
          end else begin
            r  = t;
            qu = {qu[QUO_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= r;
        nsh_q[s+1] <= ns;
        quo_q[s+1] <= qu;
        dv_q[s+1]  <= dv_q[s];
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  // last stage: apply the temperature sign
  logic signed [F_W-1:0] f_q;
  logic signed [F_W-1:0] fq;

  assign fq = {1'b0, quo_q[DIV_STG]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q <= neg_q[DIV_STG] ? -fq : fq;
    end
  end

  assign f_o = f_q;

endmodule

// File: src/rh_from_dew_point.sv
// relative humidity from air temperature and dew point, magnus formula
//
//  channel  dir  handshake                   payload
//  s_axis   in   s_axis_tvalid/tready        tdata: air_temp, dew_point
//  m_axis   out  m_axis_tvalid/tready        tdata: rel_humidity, tuser: saturated
//  cfg      in   cfg_valid_i/cfg_ready_o     cfg_data_i: units_fahrenheit
//
// one item per cycle while the output is not stalled; the pipe depth is set by the
// restoring divide, twelve taylor terms and four squarings.
// reset clears the unit register and all valid bits.
// the whole pipe holds while a result waits unaccepted at the output.
module rh_from_dew_point import rhdp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] air_temp, [31:16] dew_point
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] rel_humidity
  output logic        m_axis_tuser,   // [0] saturated
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  localparam int NSTG = MT_LAT + 3 * N_TERMS + 2 * N_SQR + 4;

  // configuration register
  logic units_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      units_q <= 1'b0;
    end else if (cfg_valid_i) begin
      units_q <= cfg_data_i;
    end
  end

  // pipe advance and valid bits
  logic            en;
  logic [NSTG-1:0] vld_q;

  assign en            = ~vld_q[NSTG-1] | m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
    end
  end

  // both temperature lanes
  logic signed [F_W-1:0] fa, fd;

  rhdp_mterm u_air (
    .clk_i  (clk_i),
    .en_i   (en),
    .fahr_i (units_q),
    .th_i   (s_axis_tdata[15:0]),
    .f_o    (fa)
  );

  rhdp_mterm u_dew (
    .clk_i  (clk_i),
    .en_i   (en),
    .fahr_i (units_q),
    .th_i   (s_axis_tdata[31:16]),
    .f_o    (fd)
  );

  // difference of terms, range flags and exponent argument
  tay_t                  tay_q [0:3*N_TERMS];
  logic signed [D_W-1:0] dd;
  tay_t                  t0;

  always_comb begin
    dd      = D_W'(fd) - D_W'(fa);
    t0      = '0;
    t0.lo   = dd < D_MIN;
    t0.hi   = dd >= D_MAX;
    t0.dneg = dd[D_W-1];
    t0.ad   = dd[D_W-1] ? AD_W'(-dd) : dd[AD_W-1:0];
    t0.mag  = Q28_ONE;
    t0.sum  = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tay_q[0] <= t0;
    end
  end

  // taylor terms: multiply, reciprocal multiply, correct
  for (genvar k = 1; k <= N_TERMS; k++) begin : g_term
    localparam logic [RCP_W-1:0] RCP      = RCP_W'((64'd1 << RCP_SH) / K_ODD[k]);
    localparam bit               NEG_TERM = ((k - 1) % 2) == 1;
    tay_t             ta, tb, tc;
    logic [MAG_W-1:0] q0;
    logic [32:0]      rsub;

    always_comb begin
      ta     = tay_q[3*k-3];
      ta.p   = PROD_W'(tay_q[3*k-3].mag) * PROD_W'(tay_q[3*k-3].ad);
      ta.sum = (tay_q[3*k-3].dneg & NEG_TERM) ?
               tay_q[3*k-3].sum - SUM_W'(tay_q[3*k-3].mag) :
               tay_q[3*k-3].sum + SUM_W'(tay_q[3*k-3].mag);

      tb     = tay_q[3*k-2];
      tb.n   = MAG_W'(tay_q[3*k-2].p >> (TAY_SH + K_SH[k]));
      tb.pm  = PM_W'(tb.n) * PM_W'(RCP);

      tc     = tay_q[3*k-1];
      q0     = tay_q[3*k-1].pm[RCP_SH +: MAG_W];
      rsub   = 33'(tay_q[3*k-1].n) - 33'(q0) * 33'(K_ODD[k]);
      tc.mag = q0 + MAG_W'(rsub >= 33'(K_ODD[k]));
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        tay_q[3*k-2] <= ta;
        tay_q[3*k-1] <= tb;
        tay_q[3*k]   <= tc;
      end
    end
  end

  // last term into the sum
  localparam bit LAST_NEG = (N_TERMS % 2) == 1;
  sqr_t                    sqr_q [0:2*N_SQR];
  logic signed [SUM_W-1:0] sum_f;
  sqr_t                    s0;

  always_comb begin
    sum_f = (tay_q[3*N_TERMS].dneg & LAST_NEG) ?
            tay_q[3*N_TERMS].sum - SUM_W'(tay_q[3*N_TERMS].mag) :
            tay_q[3*N_TERMS].sum + SUM_W'(tay_q[3*N_TERMS].mag);
    s0    = '0;
    s0.lo = tay_q[3*N_TERMS].lo;
    s0.hi = tay_q[3*N_TERMS].hi;
    s0.e  = sum_f[E_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqr_q[0] <= s0;
    end
  end

  // four squarings with rounding
  for (genvar i = 0; i < N_SQR; i++) begin : g_sqr
    sqr_t        sm, sr;
    logic [63:0] rnd;

    always_comb begin
      sm    = sqr_q[2*i];
      sm.sq = SQ_W'(sqr_q[2*i].e) * SQ_W'(sqr_q[2*i].e);
      sr    = sqr_q[2*i+1];
      rnd   = 64'(sqr_q[2*i+1].sq) + Q28_HALF;
      sr.e  = rnd[Q +: E_W];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sqr_q[2*i+1] <= sm;
        sqr_q[2*i+2] <= sr;
      end
    end
  end

  // scale to hundredths of a percent
  logic [RF_W-1:0] rf;
  logic [16:0]     rhf_q;
  logic            rlo_q, rhi_q;

  assign rf = RF_W'(sqr_q[2*N_SQR].e) * RF_W'(RH_SCALE) + RF_W'(Q28_HALF);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rhf_q <= rf[Q +: 17];
      rlo_q <= sqr_q[2*N_SQR].lo;
      rhi_q <= sqr_q[2*N_SQR].hi;
    end
  end

  // output register with saturation
  logic [RH_W-1:0] rh_q;
  logic            sat_q;
  logic            sat;

  assign sat = rhi_q | (~rlo_q & rhf_q[16]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sat_q <= sat;
      if (rlo_q) begin
        rh_q <= '0;
      end else if (sat) begin
        rh_q <= '1;
      end else begin
        rh_q <= rhf_q[RH_W-1:0];
      end
    end
  end

  assign m_axis_tvalid = vld_q[NSTG-1];
  assign m_axis_tdata  = rh_q;
  assign m_axis_tuser  = sat_q;

endmodule

// File: src/rhdp_checker.sv
// port checks for the relative humidity block
`include "rh_from_dew_point_macros.svh"

module rhdp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled result holds its value
  `RHDP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // a saturated result shows full scale
  `RHDP_ASSERT(a_sat_full, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'hffff, "saturated flag without full scale value")

  // a waiting result holds back new transactions
  `RHDP_ASSERT(a_stall_in, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input taken while output stalled")

  // nothing leaves the block in the cycle after reset is seen
  `RHDP_ASSERT_RST(a_rst_quiet, !rst_ni |=> !m_axis_tvalid, "result valid during reset")

endmodule

bind rh_from_dew_point rhdp_checker u_rhdp_checker (.*);
